>>> src/lpss_pkg.sv
// ----------------------------------------------------------------------------
// lpss_pkg
// Shared constants, types and elaboration-time table functions for the
// LTE primary sync time sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpss_pkg;

	localparam int ID_W       = 2;
	localparam int IDX_W      = 7;
	localparam int Q14_W      = 16;
	localparam int PROD_W     = 2 * Q14_W;
	localparam int ACC_W      = 38;
	localparam int OUT_W      = 22;
	localparam int RND_SHIFT  = 14;

	localparam int SEQ_LEN    = 62;
	localparam int SEQ_HALF   = SEQ_LEN / 2;
	localparam int J_W        = 6;
	localparam int SEQ_ADDR_W = ID_W + J_W;
	localparam int SEQ_DEPTH  = 3 << J_W;

	localparam int BIN_LO     = 31;
	localparam int BIN_HI     = 66;

	localparam int ROOT_0     = 25;
	localparam int ROOT_1     = 29;
	localparam int ROOT_2     = 34;

	localparam logic [ID_W-1:0] INVALID_ID = 2'd3;

	localparam int     CORDIC_STAGES   = 24;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
	} mac_ctrl_t;

	function automatic longint atan_turn(input int i);
		longint v;
		case (i)
			0:  v = 536870912;
			1:  v = 316933406;
			2:  v = 167458907;
			3:  v = 85004756;
			4:  v = 42667331;
			5:  v = 21354465;
			6:  v = 10679838;
			7:  v = 5340245;
			8:  v = 2670163;
			9:  v = 1335087;
			10: v = 667544;
			11: v = 333772;
			12: v = 166886;
			13: v = 83443;
			14: v = 41722;
			15: v = 20861;
			16: v = 10430;
			17: v = 5215;
			18: v = 2608;
			19: v = 1304;
			20: v = 652;
			21: v = 326;
			22: v = 163;
			23: v = 81;
			default: v = 0;
		endcase
		return v;
	endfunction

	// {cos, sin} in Q1.14 for a phase in 2^-32 turn units
	function automatic logic [PROD_W-1:0] cordic_q14(input logic [31:0] ang);
		logic [31:0] q;
		logic [31:0] rr;
		longint z;
		longint x;
		longint y;
		longint nx;
		longint ny;
		longint c;
		longint s;
		q  = ((ang + 32'h2000_0000) >> 30) & 32'd3;
		rr = ang - (q << 30);
		z  = longint'(signed'(rr));
		x  = CORDIC_GAIN_Q30;
		y  = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - atan_turn(i);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + atan_turn(i);
			end
			x = nx;
			y = ny;
		end
		case (q[1:0])
			2'd1: begin
				nx = -y;
				ny = x;
			end
			2'd2: begin
				nx = -x;
				ny = -y;
			end
			2'd3: begin
				nx = y;
				ny = -x;
			end
			default: begin
				nx = x;
				ny = y;
			end
		endcase
		c = (nx + 32768) >>> 16;
		s = (ny + 32768) >>> 16;
		return {c[Q14_W-1:0], s[Q14_W-1:0]};
	endfunction

	// sequence entry, index = {identity, position}
	function automatic logic [PROD_W-1:0] seq_cs(input int idx);
		int     id;
		int     j;
		longint u;
		longint m;
		longint e;
		longint r;
		longint v;
		logic [31:0] ang;
		id = idx >> J_W;
		j  = idx & ((1 << J_W) - 1);
		if (id > 2 || j >= SEQ_LEN) begin
			return '0;
		end
		u = (id == 0) ? ROOT_0 : ((id == 1) ? ROOT_1 : ROOT_2);
		m = (j + SEQ_HALF) % SEQ_LEN;
		e = (m < SEQ_HALF) ? m * (m + 1) : (m + 1) * (m + 2);
		r = (u * e) % 126;
		v = ((r << 32) + 63) / 126;
		ang = 32'(-v);
		return cordic_q14(ang);
	endfunction

endpackage

`default_nettype wire

>>> src/lpss_seq_rom.sv
// ----------------------------------------------------------------------------
// lpss_seq_rom
// Half-swapped Zadoff-Chu sequence table for all three roots, Q1.14,
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpss_seq_rom (
	input  wire logic                                  clk,
	input  wire logic [lpss_pkg::SEQ_ADDR_W-1:0]       addr,
	output logic signed [lpss_pkg::Q14_W-1:0]          zr_s1,
	output logic signed [lpss_pkg::Q14_W-1:0]          zi_s1
);

	logic [lpss_pkg::PROD_W-1:0] seq_tbl [lpss_pkg::SEQ_DEPTH];
	logic [lpss_pkg::PROD_W-1:0] rd_data;

	for (genvar g = 0; g < lpss_pkg::SEQ_DEPTH; g++) begin : g_tbl
		localparam logic [lpss_pkg::PROD_W-1:0] CS = lpss_pkg::seq_cs(g);
		assign seq_tbl[g] = CS;
	end

	assign rd_data = (addr < lpss_pkg::SEQ_ADDR_W'(lpss_pkg::SEQ_DEPTH)) ?
		seq_tbl[addr] : '0;

	always_ff @(posedge clk) begin
		zr_s1 <= rd_data[lpss_pkg::PROD_W-1:lpss_pkg::Q14_W];
		zi_s1 <= rd_data[lpss_pkg::Q14_W-1:0];
	end

endmodule

`default_nettype wire

>>> src/lpss_tw_rom.sv
// ----------------------------------------------------------------------------
// lpss_tw_rom
// Inverse DFT twiddle table, one entry per bin index modulo FFT_SIZE,
// Q1.14, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpss_tw_rom #(
	parameter int FFT_SIZE = 128
) (
	input  wire logic                             clk,
	input  wire logic [$clog2(FFT_SIZE)-1:0]      addr,
	output logic signed [lpss_pkg::Q14_W-1:0]     tr_s1,
	output logic signed [lpss_pkg::Q14_W-1:0]     ti_s1
);

	localparam int TW_W  = $clog2(FFT_SIZE);
	localparam int SHIFT = 32 - TW_W;

	logic [lpss_pkg::PROD_W-1:0] tw_tbl [FFT_SIZE];

	for (genvar g = 0; g < FFT_SIZE; g++) begin : g_tbl
		localparam logic [31:0] ANG = 32'(g) << SHIFT;
		localparam logic [lpss_pkg::PROD_W-1:0] CS = lpss_pkg::cordic_q14(ANG);
		assign tw_tbl[g] = CS;
	end

	always_ff @(posedge clk) begin
		tr_s1 <= tw_tbl[addr][lpss_pkg::PROD_W-1:lpss_pkg::Q14_W];
		ti_s1 <= tw_tbl[addr][lpss_pkg::Q14_W-1:0];
	end

endmodule

`default_nettype wire

>>> src/lpss_cmac.sv
// ----------------------------------------------------------------------------
// lpss_cmac
// Shared complex multiply-accumulate unit: registered partial products,
// then exact accumulation of real and imaginary sums.
// ----------------------------------------------------------------------------
`default_nettype none

module lpss_cmac (
	input  wire logic                                clk,
	input  wire lpss_pkg::mac_ctrl_t                 ctrl,
	input  wire logic signed [lpss_pkg::Q14_W-1:0]   zr_s1,
	input  wire logic signed [lpss_pkg::Q14_W-1:0]   zi_s1,
	input  wire logic signed [lpss_pkg::Q14_W-1:0]   tr_s1,
	input  wire logic signed [lpss_pkg::Q14_W-1:0]   ti_s1,
	output logic signed [lpss_pkg::ACC_W-1:0]        acc_re_q,
	output logic signed [lpss_pkg::ACC_W-1:0]        acc_im_q
);

	logic signed [lpss_pkg::PROD_W-1:0] p_rr_s2;
	logic signed [lpss_pkg::PROD_W-1:0] p_ii_s2;
	logic signed [lpss_pkg::PROD_W-1:0] p_ri_s2;
	logic signed [lpss_pkg::PROD_W-1:0] p_ir_s2;
	logic signed [lpss_pkg::ACC_W-1:0]  term_re;
	logic signed [lpss_pkg::ACC_W-1:0]  term_im;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			p_rr_s2 <= zr_s1 * tr_s1;
			p_ii_s2 <= zi_s1 * ti_s1;
			p_ri_s2 <= zr_s1 * ti_s1;
			p_ir_s2 <= zi_s1 * tr_s1;
		end
	end

	assign term_re = lpss_pkg::ACC_W'(p_rr_s2) - lpss_pkg::ACC_W'(p_ii_s2);
	assign term_im = lpss_pkg::ACC_W'(p_ri_s2) + lpss_pkg::ACC_W'(p_ir_s2);

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_re_q <= acc_re_q + term_re;
			acc_im_q <= acc_im_q + term_im;
		end
	end

endmodule

`default_nettype wire

>>> src/lte_pss_time_sample_generator.sv
// ----------------------------------------------------------------------------
// lte_pss_time_sample_generator
// One complex time-domain sample of the LTE primary sync symbol per command:
// direct inverse DFT over the 62 occupied bins with a shared complex MAC.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. For identity 0..2
// busy stays high after the transfer through the issue of the shared complex
// multiply-accumulate unit, one issue per occupied subcarrier, then the last
// products, the last accumulation and the rounding. The result is shown
// with a one-cycle done pulse in the next cycle, in which busy is already
// low and the next command can be taken; no command is taken while one is
// in flight. Identity 3 returns zeros with invalid_identity
// set on the very next cycle and never raises busy. done cannot be held off:
// the receiver must take the result in the cycle it is shown.
`default_nettype none

module lte_pss_time_sample_generator #(
	parameter int FFT_SIZE = 128
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [lpss_pkg::ID_W-1:0]            cell_id_in_group,
	input  wire logic [lpss_pkg::IDX_W-1:0]           sample_index,
	output logic                                      done,
	output logic signed [lpss_pkg::OUT_W-1:0]         sample_real,
	output logic signed [lpss_pkg::OUT_W-1:0]         sample_imag,
	output logic                                      invalid_identity
);

	localparam int TW_W = $clog2(FFT_SIZE);
	localparam int KN_W = TW_W + lpss_pkg::IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                              state_q;
	logic [lpss_pkg::J_W-1:0]            j_q;
	logic [lpss_pkg::ID_W-1:0]           id_q;
	logic [lpss_pkg::IDX_W-1:0]          n_q;
	logic                                v_s1;
	logic                                v_s2;
	logic                                done_q;
	logic                                accept;
	logic                                finish;

	logic [lpss_pkg::IDX_W-1:0]          cbin;
	logic [TW_W-1:0]                     k;
	logic [KN_W-1:0]                     kn;
	logic [TW_W-1:0]                     tw_addr;
	logic [lpss_pkg::SEQ_ADDR_W-1:0]     seq_addr;

	logic signed [lpss_pkg::Q14_W-1:0]   zr_s1;
	logic signed [lpss_pkg::Q14_W-1:0]   zi_s1;
	logic signed [lpss_pkg::Q14_W-1:0]   tr_s1;
	logic signed [lpss_pkg::Q14_W-1:0]   ti_s1;
	logic signed [lpss_pkg::ACC_W-1:0]   acc_re_q;
	logic signed [lpss_pkg::ACC_W-1:0]   acc_im_q;
	logic signed [lpss_pkg::ACC_W-1:0]   rnd_re;
	logic signed [lpss_pkg::ACC_W-1:0]   rnd_im;
	lpss_pkg::mac_ctrl_t                 mac_ctrl;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign finish = (state_q == ST_DRAIN) && !v_s1 && !v_s2;

	// bin of sequence position j, rotated by FFT_SIZE/2
	assign cbin = (j_q < lpss_pkg::J_W'(lpss_pkg::SEQ_HALF)) ?
		lpss_pkg::IDX_W'(j_q) + lpss_pkg::IDX_W'(lpss_pkg::BIN_LO) :
		lpss_pkg::IDX_W'(j_q) + lpss_pkg::IDX_W'(lpss_pkg::BIN_HI - lpss_pkg::SEQ_HALF);
	assign k        = TW_W'(cbin) + TW_W'(FFT_SIZE / 2);
	assign kn       = KN_W'(k) * KN_W'(n_q);
	assign tw_addr  = kn[TW_W-1:0];
	assign seq_addr = {id_q, j_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1   <= (state_q == ST_RUN);
			v_s2   <= v_s1;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						j_q <= '0;
						if (cell_id_in_group == lpss_pkg::INVALID_ID) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (j_q == lpss_pkg::J_W'(lpss_pkg::SEQ_LEN - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rnd_re = acc_re_q + lpss_pkg::ACC_W'(1 << (lpss_pkg::RND_SHIFT - 1));
	assign rnd_im = acc_im_q + lpss_pkg::ACC_W'(1 << (lpss_pkg::RND_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= cell_id_in_group;
			n_q  <= sample_index;
			if (cell_id_in_group == lpss_pkg::INVALID_ID) begin
				sample_real      <= '0;
				sample_imag      <= '0;
				invalid_identity <= 1'b1;
			end
		end else if (finish) begin
			sample_real <= rnd_re[lpss_pkg::RND_SHIFT +: lpss_pkg::OUT_W];
			sample_imag <= rnd_im[lpss_pkg::RND_SHIFT +: lpss_pkg::OUT_W];
			invalid_identity <= 1'b0;
		end
	end

	assign done = done_q;

	assign mac_ctrl.clear  = accept;
	assign mac_ctrl.mul_en = v_s1;
	assign mac_ctrl.acc_en = v_s2;

	lpss_seq_rom u_seq_rom (
		.clk   (clk),
		.addr  (seq_addr),
		.zr_s1 (zr_s1),
		.zi_s1 (zi_s1)
	);

	lpss_tw_rom #(
		.FFT_SIZE (FFT_SIZE)
	) u_tw_rom (
		.clk   (clk),
		.addr  (tw_addr),
		.tr_s1 (tr_s1),
		.ti_s1 (ti_s1)
	);

	lpss_cmac u_cmac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.zr_s1    (zr_s1),
		.zi_s1    (zi_s1),
		.tr_s1    (tr_s1),
		.ti_s1    (ti_s1),
		.acc_re_q (acc_re_q),
		.acc_im_q (acc_im_q)
	);

endmodule

`default_nettype wire

>>> src/lpss_checker.sv
// ----------------------------------------------------------------------------
// lpss_checker
// Port-level checks of the command handshake and result timing, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpss_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic [lpss_pkg::ID_W-1:0]           cell_id_in_group,
	input wire logic                                done,
	input wire logic signed [lpss_pkg::OUT_W-1:0]   sample_real,
	input wire logic signed [lpss_pkg::OUT_W-1:0]   sample_imag,
	input wire logic                                invalid_identity
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_invalid_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cell_id_in_group == lpss_pkg::INVALID_ID
		|=> done && invalid_identity && sample_real == '0 && sample_imag == '0)
		else $error("invalid identity transfer not answered with zeros");

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cell_id_in_group != lpss_pkg::INVALID_ID |=> busy)
		else $error("valid transfer did not raise busy");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && !invalid_identity)
		else $error("busy dropped without a result");

endmodule

bind lte_pss_time_sample_generator lpss_checker u_lpss_checker (.*);

`default_nettype wire

>>> bench/lte_pss_time_sample_checker.sv
// ----------------------------------------------------------------------------
// lte_pss_time_sample_checker
// Watches the command and result ports of the PSS time sample generator.
// Every accepted command is predicted with a bit-exact model: integer CORDIC
// tables for the Zadoff-Chu sequence and the twiddles, then a direct 62-term
// inverse DFT. Each done pulse is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module lte_pss_time_sample_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              busy,
	input  wire logic [lpss_pkg::ID_W-1:0]         cell_id_in_group,
	input  wire logic [lpss_pkg::IDX_W-1:0]        sample_index,
	input  wire logic                              done,
	input  wire logic signed [lpss_pkg::OUT_W-1:0] sample_real,
	input  wire logic signed [lpss_pkg::OUT_W-1:0] sample_imag,
	input  wire logic                              invalid_identity,
	output int                                     fail_count,
	output int                                     samples_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import lpss_pkg::*;

	localparam int FFT_N    = 128;
	localparam int ROT_STEPS = 24;

	typedef struct {
		logic signed [OUT_W-1:0] re;
		logic signed [OUT_W-1:0] im;
		logic                    inv;
	} pss_sample_t;

	longint      atan_step [ROT_STEPS];
	longint      zc_re [3][SEQ_LEN];
	longint      zc_im [3][SEQ_LEN];
	longint      tw_re [FFT_N];
	longint      tw_im [FFT_N];
	pss_sample_t due_samples [$];

	// cos/sin in Q1.14 of a phase in 2^-32 turn units
	function automatic void turn_to_q14(input logic [31:0] ang, output longint cs,
			output longint sn);
		logic [31:0] quad;
		logic [31:0] resid;
		longint      z;
		longint      x;
		longint      y;
		longint      nx;
		longint      ny;
		quad  = ((ang + 32'h2000_0000) >> 30) & 32'd3;
		resid = ang - (quad << 30);
		z     = longint'($signed(resid));
		x     = 64'sd652032874;
		y     = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - atan_step[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + atan_step[i];
			end
			x = nx;
			y = ny;
		end
		case (quad[1:0])
			2'd1: begin
				nx = -y;
				ny = x;
			end
			2'd2: begin
				nx = -x;
				ny = -y;
			end
			2'd3: begin
				nx = y;
				ny = -x;
			end
			default: begin
				nx = x;
				ny = y;
			end
		endcase
		cs = (nx + 32768) >>> 16;
		sn = (ny + 32768) >>> 16;
	endfunction

	function automatic pss_sample_t pss_time_sample(input logic [ID_W-1:0] id,
			input logic [IDX_W-1:0] idx);
		pss_sample_t s;
		longint      acc_re;
		longint      acc_im;
		longint      rnd_re;
		longint      rnd_im;
		int          bin;
		int          k;
		int          t;
		s.inv = (id == INVALID_ID);
		s.re  = '0;
		s.im  = '0;
		if (s.inv) begin
			return s;
		end
		acc_re = 0;
		acc_im = 0;
		for (int j = 0; j < SEQ_LEN; j++) begin
			bin = (j < SEQ_HALF) ? BIN_LO + j : BIN_HI + (j - SEQ_HALF);
			k   = (bin + FFT_N / 2) % FFT_N;
			t   = (k * int'(idx)) % FFT_N;
			acc_re += zc_re[id][j] * tw_re[t] - zc_im[id][j] * tw_im[t];
			acc_im += zc_re[id][j] * tw_im[t] + zc_im[id][j] * tw_re[t];
		end
		rnd_re = (acc_re + 8192) >>> RND_SHIFT;
		rnd_im = (acc_im + 8192) >>> RND_SHIFT;
		s.re   = rnd_re[OUT_W-1:0];
		s.im   = rnd_im[OUT_W-1:0];
		return s;
	endfunction

	task automatic report_field(input string field, input longint want, input longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		fail_count++;
	endtask

	initial begin
		longint      root;
		longint      m;
		longint      e;
		longint      r;
		longint      v;
		logic [31:0] ang;
		fail_count  = 0;
		samples_due = 0;
		atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		for (int id = 0; id < 3; id++) begin
			root = (id == 0) ? ROOT_0 : ((id == 1) ? ROOT_1 : ROOT_2);
			for (int j = 0; j < SEQ_LEN; j++) begin
				// the length-63 sequence skips its index 31 and is half-swapped onto the bins
				m   = (j + SEQ_HALF) % SEQ_LEN;
				e   = (m < SEQ_HALF) ? m * (m + 1) : (m + 1) * (m + 2);
				r   = (root * e) % 126;
				v   = -(((r << 32) + 63) / 126);
				ang = v[31:0];
				turn_to_q14(ang, zc_re[id][j], zc_im[id][j]);
			end
		end
		for (int t = 0; t < FFT_N; t++) begin
			v   = ((longint'(t) << 32) + FFT_N / 2) / FFT_N;
			ang = v[31:0];
			turn_to_q14(ang, tw_re[t], tw_im[t]);
		end
	end

	always @(posedge clk) begin
		pss_sample_t want;
		if (arst_n) begin
			if (done) begin
				if (due_samples.size() == 0) begin
					$display("%0t: result transfer with nothing outstanding, actual %0d %0d %0d",
						$time, sample_real, sample_imag, invalid_identity);
					fail_count++;
				end else begin
					want = due_samples.pop_front();
					if (sample_real !== want.re)
						report_field("sample_real", want.re, sample_real);
					if (sample_imag !== want.im)
						report_field("sample_imag", want.im, sample_imag);
					if (invalid_identity !== want.inv)
						report_field("invalid_identity", want.inv, invalid_identity);
				end
			end
			if (start && !busy)
				due_samples.push_back(pss_time_sample(cell_id_in_group, sample_index));
			samples_due = due_samples.size();
		end
	end

endmodule

>>> bench/lte_pss_time_sample_generator_tb.sv
// ----------------------------------------------------------------------------
// lte_pss_time_sample_generator_tb
// Drives commands into the PSS time sample generator: a directed sweep of
// identities and sample index corners, then random phases with varying
// sender idle rates. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module lte_pss_time_sample_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpss_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int PHASE_ITEMS  = 445;
	localparam int MAX_GAP      = 40;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [ID_W-1:0]         cell_id_in_group;
	logic [IDX_W-1:0]        sample_index;
	logic                    done;
	logic signed [OUT_W-1:0] sample_real;
	logic signed [OUT_W-1:0] sample_imag;
	logic                    invalid_identity;
	int                      fail_count;
	int                      samples_due;
	int unsigned             cycle_count;
	int                      valid_sent;
	int                      invalid_sent;
	logic [IDX_W-1:0]        corner_idx [5];
	int                      idle_pct [3];
	logic [ID_W-1:0]         rand_id;

	lte_pss_time_sample_generator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cell_id_in_group (cell_id_in_group),
		.sample_index     (sample_index),
		.done             (done),
		.sample_real      (sample_real),
		.sample_imag      (sample_imag),
		.invalid_identity (invalid_identity)
	);

	lte_pss_time_sample_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cell_id_in_group (cell_id_in_group),
		.sample_index     (sample_index),
		.done             (done),
		.sample_real      (sample_real),
		.sample_imag      (sample_imag),
		.invalid_identity (invalid_identity),
		.fail_count       (fail_count),
		.samples_due      (samples_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** lte_pss_time_sample_generator: FAILED **");
			$finish;
		end
	end

	// holds start high until the block takes the transfer
	task automatic issue_sample(input logic [ID_W-1:0] id, input logic [IDX_W-1:0] idx);
		@(negedge clk);
		start            <= 1'b1;
		cell_id_in_group <= id;
		sample_index     <= idx;
		do @(posedge clk); while (busy);
		if (id == INVALID_ID)
			invalid_sent++;
		else
			valid_sent++;
	endtask

	task automatic sender_gap(input int pct);
		int gap;
		if ($urandom_range(99) < pct) begin
			gap = $urandom_range(1, MAX_GAP);
			@(negedge clk);
			start            <= 1'b0;
			cell_id_in_group <= ID_W'($urandom);
			sample_index     <= IDX_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		wait (samples_due == 0);
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		cell_id_in_group = '0;
		sample_index     = '0;
		cycle_count      = 0;
		valid_sent       = 0;
		invalid_sent     = 0;
		corner_idx       = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd85};
		idle_pct         = '{0, 75, 28};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int id = 0; id < 4; id++)
			foreach (corner_idx[i])
				issue_sample(ID_W'(id), corner_idx[i]);
		issue_sample(2'd1, 7'd42);
		drain();

		foreach (idle_pct[p]) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				rand_id = ($urandom_range(9) == 0) ? INVALID_ID : ID_W'($urandom_range(2));
				issue_sample(rand_id, IDX_W'($urandom_range(127)));
				sender_gap(idle_pct[p]);
			end
			drain();
		end

		repeat (80) @(posedge clk);
		$display("Covered %0d samples for identities 0..2 and %0d invalid-identity commands,",
			valid_sent, invalid_sent);
		$display("directed index corners plus random phases at 0, 75 and 28 percent sender idle.");
		if (fail_count == 0)
			$display("** lte_pss_time_sample_generator: PASSED **");
		else
			$display("** lte_pss_time_sample_generator: FAILED **");
		$finish;
	end

endmodule
